[rtl/pttd_pkg.sv]
// shared types, codes and helpers of the pattern token pixel decoder
package pttd_pkg;

	// fixed field widths
	localparam int DIM_W   = 12;
	localparam int TRANS_W = 9;
	localparam int LEN_W   = 4;
	localparam int VAL_W   = 32;
	localparam int ADDR_W  = 24;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_DECODE = 2'd2;

	// error codes
	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_FULL     = 2'd1;
	localparam logic [1:0] ERR_NO_MATCH = 2'd2;
	localparam logic [1:0] ERR_COMPLETE = 2'd3;

	// register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_STRIDE = 2'd2;
	localparam logic [1:0] REG_TRANSP = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// configuration as seen by the engine
	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [DIM_W-1:0]   stride;
		logic [TRANS_W-1:0] transp;
	} cfg_t;

	// one result transaction
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  pix;
		logic [LEN_W-1:0]  used;
		logic              done;
		logic [1:0]        err;
	} res_t;

	// byte mask covering the first len characters
	function automatic logic [63:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (LEN_W'(b) < len) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

[rtl/pttd_ram.sv]
// generic single-port-write, registered-read ram
module pttd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/pttd_cfg.sv]
// apb configuration registers
module pttd_cfg
	import pttd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= '0;
			cfg_q.height <= '0;
			cfg_q.stride <= '0;
			cfg_q.transp <= '1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WIDTH:  cfg_q.width  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[DIM_W-1:0];
				REG_STRIDE: cfg_q.stride <= pwdata[DIM_W-1:0];
				REG_TRANSP: cfg_q.transp <= pwdata[TRANS_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_WIDTH:  prdata = PDATA_W'(cfg_q.width);
			REG_HEIGHT: prdata = PDATA_W'(cfg_q.height);
			REG_STRIDE: prdata = PDATA_W'(cfg_q.stride);
			REG_TRANSP: prdata = PDATA_W'(cfg_q.transp);
			default:    prdata = '0;
		endcase
	end

endmodule

[rtl/pttd_engine.sv]
// command sequencer, key table scan and raster position
module pttd_engine
	import pttd_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256,
	parameter int KEY_CHARS     = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  cfg_t                                          cfg,
	input  logic                                          in_valid,
	output logic                                          in_stall,
	input  logic [1:0]                                    cmd,
	input  logic [63:0]                                   key_bytes,
	input  logic [LEN_W-1:0]                              key_length,
	input  logic [VAL_W-1:0]                              entry_value,
	input  logic [63:0]                                   window_bytes,
	output logic                                          ram_we,
	output logic [$clog2(TABLE_ENTRIES)-1:0]              ram_waddr,
	output logic [KEY_CHARS*8+LEN_W+VAL_W-1:0]            ram_wdata,
	output logic [$clog2(TABLE_ENTRIES)-1:0]              ram_raddr,
	input  logic [KEY_CHARS*8+LEN_W+VAL_W-1:0]            ram_rdata,
	output logic                                          out_valid,
	input  logic                                          out_stall,
	output res_t                                          out_res
);

	localparam int KB    = KEY_CHARS * 8;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CW    = (IDX_W > 8) ? IDX_W : 8;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [DIM_W-1:0]   column_q, column_d;
	logic [DIM_W-1:0]   row_q, row_d;
	logic [IDX_W-1:0]   idx_s1, idx_d;
	logic [KB-1:0]      win_q, win_d;
	res_t               res_q, res_d;
	logic               out_valid_q;
	res_t               out_q;
	logic               out_load;
	logic               out_free;

	logic [IDX_W-1:0]   idx_inc;
	logic               scan_last;
	logic [KB-1:0]      key_rd;
	logic [LEN_W-1:0]   len_rd;
	logic [VAL_W-1:0]   val_rd;
	logic [63:0]        mask_rd;
	logic [63:0]        mask_wr;
	logic               hit;
	logic               trans_hit;
	logic [LEN_W-1:0]   len_clamp;
	logic [DIM_W:0]     col_inc;
	logic               wrap;
	logic [DIM_W-1:0]   row_adv;
	logic [ADDR_W-1:0]  pix_addr;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// table entry layout: value, length, key
	assign {val_rd, len_rd, key_rd} = ram_rdata;
	assign mask_rd   = prefix_mask(len_rd);
	assign hit       = ((win_q & mask_rd[KB-1:0]) == key_rd);
	assign trans_hit = ~cfg.transp[TRANS_W-1] && (CW'(idx_s1) == CW'(cfg.transp[7:0]));
	assign idx_inc   = idx_s1 + IDX_W'(1);
	assign scan_last = ((CNT_W'(idx_s1) + CNT_W'(1)) == count_q);

	// load entry formatting
	assign len_clamp = (key_length > LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS) : key_length;
	assign mask_wr   = prefix_mask(len_clamp);

	// raster position and destination address
	assign col_inc  = {1'b0, column_q} + (DIM_W+1)'(1);
	assign wrap     = (col_inc >= {1'b0, cfg.width});
	assign row_adv  = wrap ? (row_q + DIM_W'(1)) : row_q;
	assign pix_addr = ADDR_W'(column_q) + (ADDR_W'(row_q) * ADDR_W'(cfg.stride));

	// state register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			column_q    <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			column_q <= column_d;
			row_q    <= row_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_d;
		win_q  <= win_d;
		res_q  <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		column_d  = column_q;
		row_d     = row_q;
		idx_d     = idx_s1;
		win_d     = win_q;
		res_d     = res_q;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = {entry_value, len_clamp, key_bytes[KB-1:0] & mask_wr[KB-1:0]};
		ram_raddr = (state_q == ST_SCAN) ? idx_inc : '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_d   = '0;
					state_d = ST_EMIT;
					case (cmd)
						CMD_CLEAR: begin
							count_d  = '0;
							column_d = '0;
							row_d    = '0;
						end
						CMD_LOAD: begin
							if (count_q >= CNT_W'(TABLE_ENTRIES)) begin
								res_d.err = ERR_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
						end
						CMD_DECODE: begin
							win_d = window_bytes[KB-1:0];
							if (row_q >= cfg.height) begin
								res_d.err = ERR_COMPLETE;
							end else if (count_q == '0) begin
								res_d.err = ERR_NO_MATCH;
							end else begin
								// entry 0 is being read this cycle
								idx_d   = '0;
								state_d = ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					res_d.used = len_rd;
					res_d.err  = ERR_OK;
					if (!trans_hit) begin
						res_d.we   = 1'b1;
						res_d.addr = pix_addr;
						res_d.pix  = val_rd;
					end
					column_d   = wrap ? '0 : col_inc[DIM_W-1:0];
					row_d      = row_adv;
					res_d.done = (row_adv >= cfg.height);
					state_d    = ST_EMIT;
				end else if (scan_last) begin
					res_d.err = ERR_NO_MATCH;
					state_d   = ST_EMIT;
				end else begin
					idx_d = idx_inc;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/pattern_token_pixel_decoder_core.sv]
// top level of the pattern token pixel decoder
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | cmd key_bytes key_length entry_value window_bytes
//  out     | output    | out_valid/ out_stall | write_enable write_address pixel_value
//          |           |                      | consumed picture_done error
//  apb     | input     | psel penable pready  | paddr pwrite pwdata prdata
//
// a clear, load or unknown command passes through the emit state before the next is taken
// a decode with entries loaded and the picture not complete scans the table entries in order
// up to the first match, as the key table ram is read one entry per cycle
// reset empties the table through its entry count; table contents are not cleared
// a result waits in the output register while the next transaction is taken
module pattern_token_pixel_decoder_core
	import pttd_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256,
	parameter int KEY_CHARS     = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [63:0]         key_bytes,
	input  logic [LEN_W-1:0]    key_length,
	input  logic signed [VAL_W-1:0] entry_value,
	input  logic [63:0]         window_bytes,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                write_enable,
	output logic [ADDR_W-1:0]   write_address,
	output logic signed [VAL_W-1:0] pixel_value,
	output logic [LEN_W-1:0]    consumed,
	output logic                picture_done,
	output logic [1:0]          error
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int ENT_W = KEY_CHARS * 8 + LEN_W + VAL_W;

	cfg_t             cfg;
	res_t             res;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	logic [ENT_W-1:0] ram_wdata;
	logic [ENT_W-1:0] ram_rdata;

	// configuration registers
	pttd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// key table: key, length and value per entry
	pttd_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer and scan
	pttd_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_CHARS     (KEY_CHARS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.key_bytes    (key_bytes),
		.key_length   (key_length),
		.entry_value  (entry_value),
		.window_bytes (window_bytes),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_res      (res)
	);

	// result fields
	assign write_enable  = res.we;
	assign write_address = res.addr;
	assign pixel_value   = res.pix;
	assign consumed      = res.used;
	assign picture_done  = res.done;
	assign error         = res.err;

endmodule
